// ===== rtl/vss_pkg.sv =====
// vss_pkg: shared types, codes and constants of the velocity setpoint smoother
// used by velocity_setpoint_smoother_xy_unit and vss_div
package vss_pkg;

  localparam int FRAC_BITS_DEF = 16;
  localparam int VAL_W = 32;
  localparam int CFG_W = 31;
  localparam int DT_W = 17;
  localparam int CFG_IDX_W = 3;
  localparam int DIV_CNT_W = 7;

  localparam logic [CFG_IDX_W-1:0] REG_SPEED_MAX = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_MAX = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_DECEL_MIN = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_TOP = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_JERK_BOTTOM = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_ACCEL_HOVER = 3'd5;

  localparam logic [1:0] INTENT_BRAKE = 2'd0;
  localparam logic [1:0] INTENT_DIR = 2'd1;
  localparam logic [1:0] INTENT_ACCEL = 2'd2;
  localparam logic [1:0] INTENT_DECEL = 2'd3;

  typedef struct packed {
    logic start;
    logic [63:0] dividend;
    logic [32:0] divisor;
    logic [DIV_CNT_W-1:0] count;
  } div_req_t;

endpackage

// ===== rtl/vss_div.sv =====
// vss_div: restoring divider, one quotient bit per cycle, count bits per run
// depends on vss_pkg for the request struct
module vss_div (
  input  logic clk,
  input  logic rst,
  input  vss_pkg::div_req_t req,
  output logic done,
  output logic [63:0] quotient
);

  localparam int CW = vss_pkg::DIV_CNT_W;

  logic [32:0] rem;
  logic [63:0] sh;
  logic [32:0] dvs;
  logic [CW-1:0] cnt;
  logic busy;
  logic [33:0] trial;
  logic ge;

  assign trial = {rem, sh[63]};
  assign ge = trial >= {1'b0, dvs};
  assign quotient = sh;

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (req.start) begin
        rem <= 33'(req.dividend >> req.count);
        sh <= req.dividend << (CW'(64) - req.count);
        dvs <= req.divisor;
        cnt <= req.count;
        busy <= 1'b1;
      end else if (busy) begin
        rem <= ge ? 33'(trial - {1'b0, dvs}) : trial[32:0];
        sh <= {sh[62:0], ge};
        cnt <= cnt - CW'(1);
        if (cnt == CW'(1)) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/vss_sqrt.sv =====
// vss_sqrt: integer square root of a 64-bit value, one root bit per cycle
// standalone, no package use
module vss_sqrt (
  input  logic clk,
  input  logic rst,
  input  logic start,
  input  logic [63:0] radicand,
  output logic done,
  output logic [31:0] root
);

  logic [63:0] rem;
  logic [63:0] res;
  logic [63:0] bit_w;
  logic [4:0] cnt;
  logic busy;
  logic [63:0] trial;

  assign trial = res | bit_w;
  assign root = res[31:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      busy <= 1'b0;
      done <= 1'b0;
      cnt <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        rem <= radicand;
        res <= '0;
        bit_w <= 64'h4000_0000_0000_0000;
        cnt <= '0;
        busy <= 1'b1;
      end else if (busy) begin
        if (rem >= trial) begin
          rem <= rem - trial;
          res <= (res >> 1) | bit_w;
        end else begin
          res <= res >> 1;
        end
        bit_w <= bit_w >> 2;
        cnt <= cnt + 5'd1;
        if (cnt == 5'd31) begin
          busy <= 1'b0;
          done <= 1'b1;
        end
      end
    end
  end

endmodule

// ===== rtl/velocity_setpoint_smoother_xy_unit.sv =====
// velocity_setpoint_smoother_xy_unit: top level, sequencer and shared multiplier
// depends on vss_pkg, vss_div, vss_sqrt
// each transaction runs four square roots, up to four unit divisions,
// at most one 64-bit ramp division and at most one 31-bit slew division
// one transaction at a time: a new input is taken only after the last result is registered
// reset loads register defaults and clears the kept output, intent and limits
module velocity_setpoint_smoother_xy_unit #(
  parameter int FRAC_BITS = vss_pkg::FRAC_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cfg_write,
  input  logic [vss_pkg::CFG_IDX_W-1:0] cfg_index,
  input  logic [vss_pkg::CFG_W-1:0] cfg_data,
  input  logic in_valid,
  output logic in_ready,
  input  logic signed [31:0] demand_x,
  input  logic signed [31:0] demand_y,
  input  logic signed [31:0] measured_x,
  input  logic signed [31:0] measured_y,
  input  logic signed [31:0] yaw_rate_demand,
  input  logic [16:0] step_time,
  output logic out_valid,
  input  logic out_ready,
  output logic signed [31:0] smoothed_x,
  output logic signed [31:0] smoothed_y,
  output logic [1:0] intent_code,
  output logic [30:0] accel_limit
);

  localparam int UW = FRAC_BITS + 1;
  localparam int CW = vss_pkg::DIV_CNT_W;
  localparam logic [63:0] ONE_Q = 64'd1 << FRAC_BITS;
  localparam logic [63:0] ALIGN_K = (64'd707 * ONE_Q + 64'd500) / 64'd1000;
  localparam logic signed [63:0] ALIGN_T = $signed(ALIGN_K << FRAC_BITS);
  localparam logic [63:0] YAW_K = (64'd5 * ONE_Q + 64'd50) / 64'd100;
  localparam logic [63:0] TWO_Q = ONE_Q << 1;
  localparam logic [30:0] MAX31 = 31'h7FFF_FFFF;
  localparam logic [30:0] SPEED_MAX_RST = 31'(64'd12 << FRAC_BITS);
  localparam logic [30:0] ACCEL_MAX_RST = 31'(64'd10 << FRAC_BITS);
  localparam logic [30:0] DECEL_MIN_RST = 31'(64'd5 << FRAC_BITS);
  localparam logic [30:0] JERK_TOP_RST = 31'(64'd20 << FRAC_BITS);
  localparam logic [30:0] JERK_BOTTOM_RST = 31'(64'd8 << FRAC_BITS);
  localparam logic [30:0] ACCEL_HOVER_RST = 31'(64'd5 << FRAC_BITS);

  localparam logic [4:0] ST_IDLE = 5'd0;
  localparam logic [4:0] ST_SQ_A = 5'd1;
  localparam logic [4:0] ST_SQ_B = 5'd2;
  localparam logic [4:0] ST_SQ_C = 5'd3;
  localparam logic [4:0] ST_SQ_W = 5'd4;
  localparam logic [4:0] ST_UNIT_S = 5'd5;
  localparam logic [4:0] ST_UNIT_W = 5'd6;
  localparam logic [4:0] ST_DOT_A = 5'd7;
  localparam logic [4:0] ST_DOT_B = 5'd8;
  localparam logic [4:0] ST_DOT_C = 5'd9;
  localparam logic [4:0] ST_UPD = 5'd10;
  localparam logic [4:0] ST_JDIV = 5'd11;
  localparam logic [4:0] ST_JW = 5'd12;
  localparam logic [4:0] ST_RAMP_A = 5'd13;
  localparam logic [4:0] ST_RAMP_B = 5'd14;
  localparam logic [4:0] ST_ADIV = 5'd15;
  localparam logic [4:0] ST_AW = 5'd16;
  localparam logic [4:0] ST_SLEW = 5'd17;
  localparam logic [4:0] ST_ADT = 5'd18;
  localparam logic [4:0] ST_CHK = 5'd19;
  localparam logic [4:0] ST_RW = 5'd20;
  localparam logic [4:0] ST_MX = 5'd21;
  localparam logic [4:0] ST_MY = 5'd22;
  localparam logic [4:0] ST_OY = 5'd23;
  localparam logic [4:0] ST_DONE = 5'd24;

  function automatic logic [31:0] mag32(input logic signed [31:0] v);
    mag32 = v[31] ? (~v + 32'd1) : v;
  endfunction

  function automatic logic [32:0] mag33(input logic signed [32:0] v);
    mag33 = v[32] ? (~v + 33'd1) : v;
  endfunction

  function automatic logic signed [31:0] sat_add(input logic signed [31:0] base,
                                                  input logic neg,
                                                  input logic [32:0] step);
    logic signed [34:0] t;
    t = $signed({{3{base[31]}}, base}) + $signed(neg ? -{2'b0, step} : {2'b0, step});
    if (t > 35'sd2147483647) sat_add = 32'sh7FFF_FFFF;
    else if (t < -35'sd2147483648) sat_add = 32'sh8000_0000;
    else sat_add = t[31:0];
  endfunction

  logic [4:0] state;
  logic [30:0] speed_max, accel_max, decel_min, jerk_top, jerk_bottom, accel_hover;
  logic signed [31:0] dx, dy, mx, my;
  logic [16:0] dt;
  logic yaw_dem;
  logic signed [31:0] prev_x, prev_y;
  logic [1:0] last_intent;
  logic [30:0] accel_state, jerk_state;
  logic [1:0] vec, uidx;
  logic [31:0] lsp, lme, lprev;
  logic [32:0] lc;
  logic [UW-1:0] umag [4];
  logic signed [32:0] cx, cy;
  logic [30:0] r_ratio;
  logic signed [31:0] ox, oy;
  logic [1:0] intent;
  logic [65:0] prod;
  logic [63:0] acc;
  logic [32:0] ma, mb;

  logic [32:0] cmx, cmy, sq_a, sq_b;
  logic half;
  logic [31:0] unit_len, unit_mag;
  logic [30:0] vdiv, diff_mag;
  logic diff_neg;
  logic [63:0] dot_t2;
  logic signed [63:0] dot;
  logic aligned, dir_cond, decel_cond;
  logic [35:0] lsp10, smax7;
  logic signed [32:0] hover_gap;
  logic signed [65:0] gap_sh;
  logic [64:0] jsum, asum;
  logic [65:0] lc_sh, s_full;
  logic [32:0] s_step;
  logic slew_lim;
  logic [31:0] yaw_mag;

  vss_pkg::div_req_t div_req;
  logic div_done;
  logic [63:0] div_q;
  logic sq_start;
  logic sq_done;
  logic [31:0] sq_root;

  vss_div u_div (
    .clk(clk), .rst(rst), .req(div_req), .done(div_done), .quotient(div_q)
  );

  vss_sqrt u_sqrt (
    .clk(clk), .rst(rst), .start(sq_start), .radicand(acc + prod[63:0]),
    .done(sq_done), .root(sq_root)
  );

  assign in_ready = (state == ST_IDLE);
  assign sq_start = (state == ST_SQ_C);
  assign yaw_mag = mag32(yaw_rate_demand);

  assign cmx = mag33(cx);
  assign cmy = mag33(cy);
  assign half = (|cmx[32:31]) || (|cmy[32:31]);
  assign vdiv = (speed_max == '0) ? 31'd1 : speed_max;
  assign diff_neg = accel_max < decel_min;
  assign diff_mag = diff_neg ? (decel_min - accel_max) : (accel_max - decel_min);
  assign unit_len = uidx[1] ? lme : lsp;

  always_comb begin
    case (vec)
      2'd0: begin
        sq_a = {1'b0, mag32(dx)};
        sq_b = {1'b0, mag32(dy)};
      end
      2'd1: begin
        sq_a = {1'b0, mag32(mx)};
        sq_b = {1'b0, mag32(my)};
      end
      2'd2: begin
        sq_a = {1'b0, mag32(prev_x)};
        sq_b = {1'b0, mag32(prev_y)};
      end
      default: begin
        sq_a = half ? (cmx >> 1) : cmx;
        sq_b = half ? (cmy >> 1) : cmy;
      end
    endcase
    case (uidx)
      2'd0: unit_mag = mag32(dx);
      2'd1: unit_mag = mag32(dy);
      2'd2: unit_mag = mag32(mx);
      default: unit_mag = mag32(my);
    endcase
  end

  always_comb begin
    ma = '0;
    mb = '0;
    unique case (state)
      ST_SQ_A: begin
        ma = sq_a;
        mb = sq_a;
      end
      ST_SQ_B: begin
        ma = sq_b;
        mb = sq_b;
      end
      ST_DOT_A: begin
        ma = 33'(umag[0]);
        mb = 33'(umag[2]);
      end
      ST_DOT_B: begin
        ma = 33'(umag[1]);
        mb = 33'(umag[3]);
      end
      ST_UPD: begin
        ma = (intent == vss_pkg::INTENT_BRAKE) ? {2'b0, jerk_top - jerk_bottom}
                                              : {2'b0, diff_mag};
        mb = (intent == vss_pkg::INTENT_BRAKE) ? {1'b0, lme} : {1'b0, lsp};
      end
      ST_RAMP_A: begin
        ma = {2'b0, jerk_state};
        mb = 33'(dt);
      end
      ST_ADT: begin
        ma = {2'b0, accel_state};
        mb = 33'(dt);
      end
      ST_MX: begin
        ma = cmx;
        mb = {2'b0, r_ratio};
      end
      ST_MY: begin
        ma = cmy;
        mb = {2'b0, r_ratio};
      end
      default: begin
        ma = '0;
        mb = '0;
      end
    endcase
  end

  // classification terms
  assign dot_t2 = (dy[31] ^ my[31]) ? -prod[63:0] : prod[63:0];
  assign dot = $signed(acc) + $signed(dot_t2);
  assign aligned = dot > -ALIGN_T;
  assign lsp10 = ({4'b0, lsp} << 3) + ({4'b0, lsp} << 1);
  assign smax7 = ({5'b0, speed_max} << 3) - {5'b0, speed_max};
  assign dir_cond = !aligned && (lsp10 > smax7) && !yaw_dem && ({32'b0, lme} > TWO_Q);
  assign decel_cond = aligned && (lsp < lprev) && !yaw_dem;

  // braking ramp and limit terms
  assign hover_gap = $signed({2'b0, accel_hover}) - $signed({2'b0, accel_state});
  assign gap_sh = $signed({{33{hover_gap[32]}}, hover_gap}) <<< FRAC_BITS;
  assign jsum = 65'(div_q) + 65'(jerk_bottom);
  assign asum = 65'(div_q) + 65'(decel_min);

  // slew limit terms
  assign lc_sh = 66'(lc) << FRAC_BITS;
  assign slew_lim = (lc != '0) && (lc_sh > prod);
  assign s_full = prod >> FRAC_BITS;
  assign s_step = (s_full > 66'(lc)) ? lc : s_full[32:0];

  always_comb begin
    div_req = '0;
    unique case (state)
      ST_UNIT_S: begin
        div_req.start = (unit_len != '0);
        div_req.dividend = 64'(unit_mag) << FRAC_BITS;
        div_req.divisor = 33'(unit_len);
        div_req.count = CW'(FRAC_BITS + 1);
      end
      ST_JDIV, ST_ADIV: begin
        div_req.start = 1'b1;
        div_req.dividend = prod[63:0];
        div_req.divisor = {2'b0, vdiv};
        div_req.count = CW'(64);
      end
      ST_CHK: begin
        div_req.start = slew_lim;
        div_req.dividend = 64'(s_step) << 30;
        div_req.divisor = lc;
        div_req.count = CW'(31);
      end
      default: div_req = '0;
    endcase
  end

  always_ff @(posedge clk) begin
    prod <= 66'(ma) * 66'(mb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      speed_max <= SPEED_MAX_RST;
      accel_max <= ACCEL_MAX_RST;
      decel_min <= DECEL_MIN_RST;
      jerk_top <= JERK_TOP_RST;
      jerk_bottom <= JERK_BOTTOM_RST;
      accel_hover <= ACCEL_HOVER_RST;
    end else if (cfg_write) begin
      unique case (cfg_index)
        vss_pkg::REG_SPEED_MAX: speed_max <= cfg_data;
        vss_pkg::REG_ACCEL_MAX: accel_max <= cfg_data;
        vss_pkg::REG_DECEL_MIN: decel_min <= cfg_data;
        vss_pkg::REG_JERK_TOP: jerk_top <= cfg_data;
        vss_pkg::REG_JERK_BOTTOM: jerk_bottom <= cfg_data;
        vss_pkg::REG_ACCEL_HOVER: accel_hover <= cfg_data;
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
      out_valid <= 1'b0;
      prev_x <= '0;
      prev_y <= '0;
      last_intent <= vss_pkg::INTENT_BRAKE;
      accel_state <= '0;
      jerk_state <= '0;
      vec <= '0;
      uidx <= '0;
    end else begin
      if (out_valid && out_ready && state != ST_DONE) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        ST_IDLE: begin
          if (in_valid) begin
            dx <= demand_x;
            dy <= demand_y;
            mx <= measured_x;
            my <= measured_y;
            dt <= (step_time == '0) ? 17'd1 : step_time;
            yaw_dem <= 64'(yaw_mag) > YAW_K;
            vec <= 2'd0;
            state <= ST_SQ_A;
          end
        end
        ST_SQ_A: state <= ST_SQ_B;
        ST_SQ_B: begin
          acc <= prod[63:0];
          state <= ST_SQ_C;
        end
        ST_SQ_C: state <= ST_SQ_W;
        ST_SQ_W: begin
          if (sq_done) begin
            case (vec)
              2'd0: begin
                lsp <= sq_root;
                vec <= 2'd1;
                state <= ST_SQ_A;
              end
              2'd1: begin
                lme <= sq_root;
                vec <= 2'd2;
                state <= ST_SQ_A;
              end
              2'd2: begin
                lprev <= sq_root;
                uidx <= 2'd0;
                if (dx == '0 && dy == '0) begin
                  intent <= vss_pkg::INTENT_BRAKE;
                  state <= ST_UPD;
                end else begin
                  state <= ST_UNIT_S;
                end
              end
              default: begin
                lc <= half ? {sq_root, 1'b0} : {1'b0, sq_root};
                state <= ST_ADT;
              end
            endcase
          end
        end
        ST_UNIT_S: begin
          if (unit_len == '0) begin
            umag[uidx] <= '0;
            uidx <= uidx + 2'd1;
            if (uidx == 2'd3) state <= ST_DOT_A;
          end else begin
            state <= ST_UNIT_W;
          end
        end
        ST_UNIT_W: begin
          if (div_done) begin
            umag[uidx] <= div_q[UW-1:0];
            uidx <= uidx + 2'd1;
            state <= (uidx == 2'd3) ? ST_DOT_A : ST_UNIT_S;
          end
        end
        ST_DOT_A: state <= ST_DOT_B;
        ST_DOT_B: begin
          acc <= (dx[31] ^ mx[31]) ? -prod[63:0] : prod[63:0];
          state <= ST_DOT_C;
        end
        ST_DOT_C: begin
          if (dir_cond) intent <= vss_pkg::INTENT_DIR;
          else if (decel_cond) intent <= vss_pkg::INTENT_DECEL;
          else intent <= vss_pkg::INTENT_ACCEL;
          state <= ST_UPD;
        end
        ST_UPD: begin
          last_intent <= intent;
          case (intent)
            vss_pkg::INTENT_BRAKE: begin
              state <= ST_RAMP_A;
              if (last_intent == vss_pkg::INTENT_DIR) begin
                jerk_state <= MAX31;
                prev_x <= mx;
                prev_y <= my;
              end else if (last_intent != vss_pkg::INTENT_BRAKE) begin
                accel_state <= decel_min;
                jerk_state <= MAX31;
                prev_x <= mx;
                prev_y <= my;
                if (jerk_top > jerk_bottom) state <= ST_JDIV;
              end
            end
            vss_pkg::INTENT_DIR: begin
              prev_x <= dx;
              prev_y <= dy;
              accel_state <= accel_max;
              state <= ST_SLEW;
            end
            vss_pkg::INTENT_ACCEL: state <= ST_ADIV;
            default: begin
              accel_state <= decel_min;
              state <= ST_SLEW;
            end
          endcase
        end
        ST_JDIV: state <= ST_JW;
        ST_JW: begin
          if (div_done) begin
            jerk_state <= (jsum < 65'(jerk_top)) ? jsum[30:0] : jerk_top;
            state <= ST_RAMP_A;
          end
        end
        ST_RAMP_A: state <= ST_RAMP_B;
        ST_RAMP_B: begin
          if (gap_sh > $signed(prod)) begin
            accel_state <= accel_state + prod[FRAC_BITS +: 31];
          end else begin
            accel_state <= accel_hover;
          end
          state <= ST_SLEW;
        end
        ST_ADIV: state <= ST_AW;
        ST_AW: begin
          if (div_done) begin
            if (diff_neg) begin
              accel_state <= (div_q > 64'(decel_min)) ? 31'd0 : (decel_min - div_q[30:0]);
            end else begin
              accel_state <= (asum > 65'(MAX31)) ? MAX31 : asum[30:0];
            end
            state <= ST_SLEW;
          end
        end
        ST_SLEW: begin
          cx <= $signed({dx[31], dx}) - $signed({prev_x[31], prev_x});
          cy <= $signed({dy[31], dy}) - $signed({prev_y[31], prev_y});
          vec <= 2'd3;
          state <= ST_SQ_A;
        end
        ST_ADT: state <= ST_CHK;
        ST_CHK: begin
          if (slew_lim) begin
            state <= ST_RW;
          end else begin
            ox <= dx;
            oy <= dy;
            state <= ST_DONE;
          end
        end
        ST_RW: begin
          if (div_done) begin
            r_ratio <= div_q[30:0];
            state <= ST_MX;
          end
        end
        ST_MX: state <= ST_MY;
        ST_MY: begin
          ox <= sat_add(prev_x, cx[32], prod[62:30]);
          state <= ST_OY;
        end
        ST_OY: begin
          oy <= sat_add(prev_y, cy[32], prod[62:30]);
          state <= ST_DONE;
        end
        ST_DONE: begin
          if (!out_valid || out_ready) begin
            smoothed_x <= ox;
            smoothed_y <= oy;
            intent_code <= intent;
            accel_limit <= accel_state;
            prev_x <= ox;
            prev_y <= oy;
            out_valid <= 1'b1;
            state <= ST_IDLE;
          end
        end
        default: state <= ST_IDLE;
      endcase
    end
  end

endmodule

// ===== tb/sv/tb_velocity_setpoint_smoother_xy_unit.sv =====
// tb_velocity_setpoint_smoother_xy_unit: self-checking testbench for the setpoint smoother
// predicts every transaction in fixed point and compares it field by field
// depends on vss_pkg and velocity_setpoint_smoother_xy_unit
`timescale 1ns / 100ps

module tb_velocity_setpoint_smoother_xy_unit;

  localparam int FB = vss_pkg::FRAC_BITS_DEF;
  localparam longint unsigned ONE_Q = 64'd1 << FB;
  localparam longint unsigned ALIGN_K = (707 * ONE_Q + 500) / 1000;
  localparam longint unsigned YAW_K = (5 * ONE_Q + 50) / 100;
  localparam longint MAX31 = 64'h7FFF_FFFF;
  localparam int SETTLE = 400;
  localparam int CYCLE_LIMIT = 3000000;

  typedef struct packed {
    logic [31:0] sx;
    logic [31:0] sy;
    logic [1:0] intent;
    logic [30:0] limit;
  } smooth_res_t;

  logic clk = 1'b0;
  logic rst = 1'b1;
  logic cfg_write = 1'b0;
  logic [vss_pkg::CFG_IDX_W-1:0] cfg_index = '0;
  logic [vss_pkg::CFG_W-1:0] cfg_data = '0;
  logic in_valid = 1'b0;
  logic in_ready;
  logic signed [31:0] demand_x = '0, demand_y = '0, measured_x = '0, measured_y = '0;
  logic signed [31:0] yaw_rate_demand = '0;
  logic [16:0] step_time = 17'd1;
  logic out_valid;
  logic out_ready = 1'b0;
  logic signed [31:0] smoothed_x, smoothed_y;
  logic [1:0] intent_code;
  logic [30:0] accel_limit;

  smooth_res_t expected_q[$];
  int mismatches = 0;
  int cycles = 0;
  bit quiet = 1'b0;

  // predictor state and register copy
  longint unsigned reg_val[6];
  longint prev_x, prev_y, accel_st, jerk_st;
  logic [1:0] last_int;

  velocity_setpoint_smoother_xy_unit dut (.*);

  always #10 clk = ~clk;

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("velocity_setpoint_smoother_xy_unit regression: fail");
      $finish;
    end
  end

  function automatic longint unsigned isqrt(longint unsigned v);
    longint unsigned r, b;
    r = 0;
    b = 64'd1 << 62;
    while (b > v) b >>= 2;
    while (b != 0) begin
      if (v >= r + b) begin
        v = v - (r + b);
        r = (r >> 1) + b;
      end else begin
        r >>= 1;
      end
      b >>= 2;
    end
    return r;
  endfunction

  function automatic longint unsigned mag(longint v);
    return (v < 0) ? longint'(-v) : v;
  endfunction

  function automatic longint unsigned vec_len(longint x, longint y);
    return isqrt(mag(x) * mag(x) + mag(y) * mag(y));
  endfunction

  function automatic longint unit_part(longint c, longint unsigned len);
    longint unsigned q;
    q = (mag(c) << FB) / len;
    return (c < 0) ? -longint'(q) : longint'(q);
  endfunction

  function automatic longint sat32(longint v);
    if (v > MAX31) return MAX31;
    if (v < -64'sh8000_0000) return -64'sh8000_0000;
    return v;
  endfunction

  function automatic logic [1:0] classify_intent(longint dx, longint dy, longint mx, longint my,
                                                 longint yaw, longint unsigned lsp,
                                                 longint unsigned lme);
    longint ux, uy, vx, vy, dot;
    bit aligned, yawdem;
    ux = 0; uy = 0; vx = 0; vy = 0;
    if (dx == 0 && dy == 0) return vss_pkg::INTENT_BRAKE;
    if (lsp > 0) begin
      ux = unit_part(dx, lsp);
      uy = unit_part(dy, lsp);
    end
    if (lme > 0) begin
      vx = unit_part(mx, lme);
      vy = unit_part(my, lme);
    end
    dot = ux * vx + uy * vy;
    aligned = dot > -longint'(ALIGN_K * ONE_Q);
    yawdem = mag(yaw) > YAW_K;
    if (!aligned && lsp * 10 > reg_val[vss_pkg::REG_SPEED_MAX] * 7 && !yawdem &&
        lme > 2 * ONE_Q)
      return vss_pkg::INTENT_DIR;
    if (aligned && lsp < vec_len(prev_x, prev_y) && !yawdem) return vss_pkg::INTENT_DECEL;
    return vss_pkg::INTENT_ACCEL;
  endfunction

  function automatic smooth_res_t smooth_step(logic signed [31:0] idx, logic signed [31:0] idy,
                                              logic signed [31:0] imx, logic signed [31:0] imy,
                                              logic signed [31:0] iyaw, logic [16:0] idt);
    longint dx, dy, mx, my, yaw, ox, oy, cx, cy, d, diff, v;
    longint unsigned dt, vdiv, lsp, lme, ax, ay, lc, adt, j, q, s, r, mxs, mys;
    logic [1:0] intent;
    int half;
    smooth_res_t res;
    dx = idx; dy = idy; mx = imx; my = imy; yaw = iyaw;
    dt = (idt == 0) ? 1 : idt;
    vdiv = (reg_val[vss_pkg::REG_SPEED_MAX] != 0) ? reg_val[vss_pkg::REG_SPEED_MAX] : 1;
    lsp = vec_len(dx, dy);
    lme = vec_len(mx, my);
    ox = dx; oy = dy; half = 0;
    intent = classify_intent(dx, dy, mx, my, yaw, lsp, lme);
    case (intent)
      vss_pkg::INTENT_BRAKE: begin
        if (last_int == vss_pkg::INTENT_DIR) begin
          jerk_st = MAX31;
          prev_x = mx; prev_y = my;
        end else if (last_int != vss_pkg::INTENT_BRAKE) begin
          accel_st = reg_val[vss_pkg::REG_DECEL_MIN];
          jerk_st = MAX31;
          if (reg_val[vss_pkg::REG_JERK_TOP] > reg_val[vss_pkg::REG_JERK_BOTTOM]) begin
            j = (reg_val[vss_pkg::REG_JERK_TOP] - reg_val[vss_pkg::REG_JERK_BOTTOM]) * lme /
                vdiv + reg_val[vss_pkg::REG_JERK_BOTTOM];
            jerk_st = (j < reg_val[vss_pkg::REG_JERK_TOP]) ? j : reg_val[vss_pkg::REG_JERK_TOP];
          end
          prev_x = mx; prev_y = my;
        end
        d = longint'(reg_val[vss_pkg::REG_ACCEL_HOVER]) - accel_st;
        if (d * longint'(ONE_Q) > jerk_st * longint'(dt))
          accel_st = accel_st + longint'((unsigned'(jerk_st) * dt) >> FB);
        else
          accel_st = reg_val[vss_pkg::REG_ACCEL_HOVER];
      end
      vss_pkg::INTENT_DIR: begin
        prev_x = dx; prev_y = dy;
        accel_st = reg_val[vss_pkg::REG_ACCEL_MAX];
      end
      vss_pkg::INTENT_ACCEL: begin
        diff = longint'(reg_val[vss_pkg::REG_ACCEL_MAX]) -
               longint'(reg_val[vss_pkg::REG_DECEL_MIN]);
        q = mag(diff) * lsp / vdiv;
        v = longint'(reg_val[vss_pkg::REG_DECEL_MIN]) +
            ((diff < 0) ? -longint'(q) : longint'(q));
        accel_st = (v < 0) ? 0 : ((v > MAX31) ? MAX31 : v);
      end
      default: accel_st = reg_val[vss_pkg::REG_DECEL_MIN];
    endcase
    last_int = intent;
    cx = dx - prev_x;
    cy = dy - prev_y;
    ax = mag(cx); ay = mag(cy);
    if (ax >= 64'h8000_0000 || ay >= 64'h8000_0000) begin
      half = 1;
      ax >>= 1; ay >>= 1;
    end
    lc = isqrt(ax * ax + ay * ay) << half;
    adt = unsigned'(accel_st) * dt;
    if (lc > 0 && lc * ONE_Q > adt) begin
      s = adt >> FB;
      if (s > lc) s = lc;
      r = (s << 30) / lc;
      mxs = (mag(cx) * r) >> 30;
      mys = (mag(cy) * r) >> 30;
      ox = sat32(prev_x + ((cx < 0) ? -longint'(mxs) : longint'(mxs)));
      oy = sat32(prev_y + ((cy < 0) ? -longint'(mys) : longint'(mys)));
    end
    prev_x = ox;
    prev_y = oy;
    res.sx = ox[31:0];
    res.sy = oy[31:0];
    res.intent = intent;
    res.limit = accel_st[30:0];
    return res;
  endfunction

  // result side: random stall, compare with oldest expectation
  always @(posedge clk) begin
    smooth_res_t e;
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      out_ready <= quiet || ($urandom_range(99) >= 7);
      if (out_valid && out_ready) begin
        if (expected_q.size() == 0) begin
          mismatches++;
          if (mismatches <= 10) $display("unexpected transaction at cycle %0d", cycles);
        end else begin
          e = expected_q.pop_front();
          if (e.sx !== smoothed_x || e.sy !== smoothed_y || e.intent !== intent_code ||
              e.limit !== accel_limit) begin
            mismatches++;
            if (mismatches <= 10)
              $display("mismatch cycle %0d: exp x=%h y=%h i=%0d a=%h got x=%h y=%h i=%0d a=%h",
                       cycles, e.sx, e.sy, e.intent, e.limit,
                       smoothed_x, smoothed_y, intent_code, accel_limit);
          end
        end
      end
    end
  end

  task automatic send_item(logic [31:0] dx, logic [31:0] dy, logic [31:0] mx, logic [31:0] my,
                           logic [31:0] yaw, logic [16:0] dt);
    @(posedge clk);
    if (!quiet && $urandom_range(99) < 7) begin
      @(posedge clk);
      while ($urandom_range(99) < 50) @(posedge clk);
    end
    in_valid <= 1'b1;
    demand_x <= dx; demand_y <= dy; measured_x <= mx; measured_y <= my;
    yaw_rate_demand <= yaw; step_time <= dt;
    do @(posedge clk); while (!in_ready);
    in_valid <= 1'b0;
    expected_q.push_back(smooth_step(dx, dy, mx, my, yaw, dt));
  endtask

  task automatic set_config(longint unsigned v0, longint unsigned v1, longint unsigned v2,
                            longint unsigned v3, longint unsigned v4, longint unsigned v5);
    longint unsigned vals[6];
    vals = '{v0, v1, v2, v3, v4, v5};
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    for (int i = 0; i < 6; i++) begin
      cfg_write <= 1'b1;
      cfg_index <= i[vss_pkg::CFG_IDX_W-1:0];
      cfg_data <= vals[i][vss_pkg::CFG_W-1:0];
      reg_val[i] = vals[i] & 64'h7FFF_FFFF;
      @(posedge clk);
    end
    cfg_write <= 1'b0;
  endtask

  function automatic logic [31:0] rand_val();
    case ($urandom_range(9))
      0: return $urandom;
      1: case ($urandom_range(3))
           0: return 32'h8000_0000;
           1: return 32'h7FFF_FFFF;
           2: return 32'h0;
           default: return 32'hFFFF_FFFF;
         endcase
      default: return $urandom_range(32'h0040_0000) - 32'h0020_0000;
    endcase
  endfunction

  function automatic logic [16:0] rand_dt();
    case ($urandom_range(9))
      0: return 17'd1;
      1: return 17'h10000;
      2: return $urandom_range(17'h10000, 1);
      default: return $urandom_range(1311, 65);
    endcase
  endfunction

  task automatic test_directed();
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd655);
    send_item(32'h0010_0000, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 17'd655);
    send_item(32'h0010_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 17'h10000);
    send_item(32'h0004_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0, 17'd655);
    send_item(32'h0004_0000, 32'h0, 32'h0010_0000, 32'h0, 32'h0001_0000, 17'd655);
    send_item(32'h0, 32'h0, 32'h000C_0000, 32'h0, 32'h0, 17'd1000);
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd0);
    send_item(32'hFFF4_0000, 32'h0, 32'h0008_0000, 32'h0, 32'h0, 17'd655);
    send_item(32'h0, 32'h0, 32'h0008_0000, 32'h0001_0000, 32'h0, 17'd655);
    send_item(32'h0, 32'h0, 32'h0, 32'h0, 32'h0, 17'd1);
    send_item(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h8000_0000, 32'h8000_0000, 32'h0, 17'h10000);
    send_item(32'h8000_0000, 32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h0, 17'h10000);
    send_item(32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000, 32'h7FFF_FFFF, 32'h8000_0000,
              17'd1);
    send_item(32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 32'h7FFF_FFFF, 17'hFFFF);
    send_item(32'h0, 32'h0, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 17'h10000);
    send_item(32'h0000_0001, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0000_0001, 32'h0000_0CCD,
              17'd2);
  endtask

  task automatic test_random(int count);
    logic [31:0] dx, dy, mx, my, yaw;
    for (int n = 0; n < count; n++) begin
      quiet = (n % 300) >= 240;
      dx = rand_val(); dy = rand_val();
      case ($urandom_range(5))
        0: begin mx = -dx; my = -dy; end
        1: begin mx = dx; my = dy; end
        default: begin mx = rand_val(); my = rand_val(); end
      endcase
      if ($urandom_range(9) == 0) begin dx = 0; dy = 0; end
      yaw = ($urandom_range(3) == 0) ? rand_val() : $urandom_range(6554) - 3277;
      send_item(dx, dy, mx, my, yaw, rand_dt());
    end
    quiet = 1'b0;
  endtask

  task automatic test_config_sweep();
    set_config(64'h10000, 64'h0, 64'h0, 64'h0, 64'h0, 64'h0);
    test_random(60);
    set_config(64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF, 64'h7FFF_FFFF,
               64'h7FFF_FFFF);
    test_random(60);
    set_config(64'h0, 64'h7FFF_FFFF, 64'h0, 64'h0008_0000, 64'h0014_0000, 64'h7FFF_FFFF);
    test_directed();
    set_config(64'h10000, 64'h0005_0000, 64'h000A_0000, 64'h7FFF_FFFF, 64'h0, 64'h0002_0000);
    test_random(60);
  endtask

  initial begin
    reg_val = '{64'd786432, 64'd655360, 64'd327680, 64'd1310720, 64'd524288, 64'd327680};
    prev_x = 0; prev_y = 0; accel_st = 0; jerk_st = 0; last_int = vss_pkg::INTENT_BRAKE;
    repeat (3) @(posedge clk);
    rst <= 1'b0;
    test_directed();
    test_config_sweep();
    set_config(64'd786432, 64'd655360, 64'd327680, 64'd1310720, 64'd524288, 64'd327680);
    test_random(900);
    @(posedge clk);
    in_valid <= 1'b0;
    while (expected_q.size() > 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
    if (mismatches == 0 && expected_q.size() == 0)
      $display("velocity_setpoint_smoother_xy_unit regression: pass");
    else
      $display("velocity_setpoint_smoother_xy_unit regression: fail");
    $finish;
  end

endmodule
